/* rtl/core/jsu_pkg.sv */
// Package for the JSON string unescaper: mode and result codes, beat
// structs and character constants. No dependencies.
package jsu_pkg;

    localparam int unsigned MaxResults = 3;   // most result beats from one input beat
    localparam int unsigned QueueDepth = 8;   // default result queue depth (power of two)

    typedef enum logic [2:0]
    {
        MODE_IDLE = 3'd0,
        MODE_STR  = 3'd1,
        MODE_ESC  = 3'd2,
        MODE_HEX  = 3'd3,
        MODE_ELF  = 3'd4,
        MODE_ECR  = 3'd5
    } mode_t;

    typedef enum logic [2:0]
    {
        KIND_BYTE   = 3'd0,
        KIND_DONE   = 3'd1,
        KIND_BADU   = 3'd2,
        KIND_BADESC = 3'd3,
        KIND_CTRL   = 3'd4,
        KIND_UNTERM = 3'd5,
        KIND_CUT    = 3'd6
    } kind_t;

    typedef struct packed
    {
        logic [7:0] out_byte;
        kind_t      kind;
        logic       last;
    } result_t;

    // Results caused by one input beat, entry 0 first.
    typedef struct packed
    {
        logic [1:0]                  count;
        result_t [MaxResults-1:0]    res;
    } burst_t;

    localparam logic [7:0] ChrDquote = 8'h22;
    localparam logic [7:0] ChrSquote = 8'h27;
    localparam logic [7:0] ChrBslash = 8'h5C;
    localparam logic [7:0] ChrSlash  = 8'h2F;
    localparam logic [7:0] ChrBs     = 8'h08;
    localparam logic [7:0] ChrFf     = 8'h0C;
    localparam logic [7:0] ChrLf     = 8'h0A;
    localparam logic [7:0] ChrCr     = 8'h0D;
    localparam logic [7:0] ChrTab    = 8'h09;
    localparam logic [7:0] ChrLowB   = 8'h62;
    localparam logic [7:0] ChrLowF   = 8'h66;
    localparam logic [7:0] ChrLowN   = 8'h6E;
    localparam logic [7:0] ChrLowR   = 8'h72;
    localparam logic [7:0] ChrLowT   = 8'h74;
    localparam logic [7:0] ChrLowU   = 8'h75;

    localparam logic [7:0] Utf8Cont  = 8'h80;
    localparam logic [7:0] Utf8Lead2 = 8'hC0;
    localparam logic [7:0] Utf8Lead3 = 8'hE0;
    localparam logic [5:0] Utf8Mask  = 6'h3F;

    // Hex digit decode: bit 4 set when c is a hex digit of either case.
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] r;
        r = '0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            r = {1'b1, c[3:0]};
        end
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
        begin
            r = {1'b1, c[3:0] + 4'h9};
        end
        return r;
    endfunction

endpackage

/* rtl/core/jsu_if.sv */
// Valid/ready channel interfaces for the unescaper's input and result beats.
// Depends on jsu_pkg.
interface jsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_input;

    modport source (output valid, output in_byte, output end_of_input, input ready);
    modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface jsu_out_if;
    logic          valid;
    logic          ready;
    logic [7:0]    out_byte;
    jsu_pkg::kind_t kind;
    logic          last;

    modport source (output valid, output out_byte, output kind, output last, input ready);
    modport sink   (input valid, input out_byte, input kind, input last, output ready);
endinterface

/* rtl/core/jsu_decode.sv */
// Per-beat decode: string/escape/hex state registers and the logic that
// turns one source byte into 0..3 result beats. Depends on jsu_pkg.
module jsu_decode
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step_en,
    input  logic [7:0]      in_byte,
    input  logic            end_of_input,
    output jsu_pkg::burst_t burst
);

    jsu_pkg::mode_t mode_reg, mode_next;
    logic           quote_dbl_reg, quote_dbl_next;
    logic [1:0]     digits_reg, digits_next;
    logic [15:0]    code_unit_reg, code_unit_next;

    // Byte handled as string content (also after a line continuation).
    jsu_pkg::mode_t   str_mode;
    logic             str_has;
    jsu_pkg::result_t str_res;

    logic [4:0]  hex;
    logic [15:0] cu_shift;

    assign hex      = jsu_pkg::hex_val(in_byte);
    assign cu_shift = {code_unit_reg[11:0], hex[3:0]};

    always_comb
    begin
        str_mode = jsu_pkg::MODE_STR;
        str_has  = 1'b1;
        str_res  = '{out_byte: in_byte, kind: jsu_pkg::KIND_BYTE, last: 1'b0};
        priority if (end_of_input)
        begin
            str_mode = jsu_pkg::MODE_IDLE;
            str_res  = '{out_byte: 8'h00, kind: jsu_pkg::KIND_UNTERM, last: 1'b0};
        end
        else if ((in_byte == jsu_pkg::ChrDquote && quote_dbl_reg) ||
                 (in_byte == jsu_pkg::ChrSquote && !quote_dbl_reg))
        begin
            str_mode = jsu_pkg::MODE_IDLE;
            str_res  = '{out_byte: 8'h00, kind: jsu_pkg::KIND_DONE, last: 1'b0};
        end
        else if (in_byte == jsu_pkg::ChrBslash)
        begin
            str_mode = jsu_pkg::MODE_ESC;
            str_has  = 1'b0;
        end
        else if (in_byte == jsu_pkg::ChrBs || in_byte == jsu_pkg::ChrFf ||
                 in_byte == jsu_pkg::ChrLf || in_byte == jsu_pkg::ChrCr)
        begin
            str_mode = jsu_pkg::MODE_IDLE;
            str_res  = '{out_byte: 8'h00, kind: jsu_pkg::KIND_CTRL, last: 1'b0};
        end
        else
        begin
        end
    end

    always_comb
    begin
        mode_next      = mode_reg;
        quote_dbl_next = quote_dbl_reg;
        digits_next    = digits_reg;
        code_unit_next = code_unit_reg;
        burst          = '0;

        unique case (mode_reg)
            jsu_pkg::MODE_STR:
            begin
                mode_next    = str_mode;
                burst.count  = {1'b0, str_has};
                burst.res[0] = str_res;
            end
            jsu_pkg::MODE_ESC:
            begin
                mode_next    = jsu_pkg::MODE_STR;
                burst.count  = 2'd1;
                burst.res[0].kind = jsu_pkg::KIND_BYTE;
                if (end_of_input)
                begin
                    mode_next         = jsu_pkg::MODE_IDLE;
                    burst.res[0].kind = jsu_pkg::KIND_CUT;
                end
                else
                begin
                    unique case (in_byte)
                        jsu_pkg::ChrDquote: burst.res[0].out_byte = jsu_pkg::ChrDquote;
                        jsu_pkg::ChrSquote: burst.res[0].out_byte = jsu_pkg::ChrSquote;
                        jsu_pkg::ChrBslash: burst.res[0].out_byte = jsu_pkg::ChrBslash;
                        jsu_pkg::ChrSlash:  burst.res[0].out_byte = jsu_pkg::ChrSlash;
                        jsu_pkg::ChrLowB:   burst.res[0].out_byte = jsu_pkg::ChrBs;
                        jsu_pkg::ChrLowF:   burst.res[0].out_byte = jsu_pkg::ChrFf;
                        jsu_pkg::ChrLowN:   burst.res[0].out_byte = jsu_pkg::ChrLf;
                        jsu_pkg::ChrLowR:   burst.res[0].out_byte = jsu_pkg::ChrCr;
                        jsu_pkg::ChrLowT:   burst.res[0].out_byte = jsu_pkg::ChrTab;
                        jsu_pkg::ChrLowU:
                        begin
                            mode_next      = jsu_pkg::MODE_HEX;
                            digits_next    = 2'd0;
                            code_unit_next = '0;
                            burst.count    = 2'd0;
                        end
                        jsu_pkg::ChrLf:
                        begin
                            mode_next   = jsu_pkg::MODE_ELF;
                            burst.count = 2'd0;
                        end
                        jsu_pkg::ChrCr:
                        begin
                            mode_next   = jsu_pkg::MODE_ECR;
                            burst.count = 2'd0;
                        end
                        default:
                        begin
                            mode_next         = jsu_pkg::MODE_IDLE;
                            burst.res[0].kind = jsu_pkg::KIND_BADESC;
                        end
                    endcase
                end
            end
            jsu_pkg::MODE_HEX:
            begin
                if (end_of_input || !hex[4])
                begin
                    mode_next         = jsu_pkg::MODE_IDLE;
                    digits_next       = 2'd0;
                    burst.count       = 2'd1;
                    burst.res[0].kind = jsu_pkg::KIND_BADU;
                end
                else
                begin
                    code_unit_next = cu_shift;
                    digits_next    = digits_reg + 2'd1;
                    if (digits_reg == 2'd3)
                    begin
                        mode_next = jsu_pkg::MODE_STR;
                        priority if (cu_shift < 16'h0080)
                        begin
                            burst.count           = 2'd1;
                            burst.res[0].out_byte = cu_shift[7:0];
                        end
                        else if (cu_shift < 16'h0800)
                        begin
                            burst.count           = 2'd2;
                            burst.res[0].out_byte = jsu_pkg::Utf8Lead2 | {3'b000, cu_shift[10:6]};
                            burst.res[1].out_byte = jsu_pkg::Utf8Cont
                                                  | {2'b00, cu_shift[5:0] & jsu_pkg::Utf8Mask};
                        end
                        else
                        begin
                            burst.count           = 2'd3;
                            burst.res[0].out_byte = jsu_pkg::Utf8Lead3 | {4'h0, cu_shift[15:12]};
                            burst.res[1].out_byte = jsu_pkg::Utf8Cont
                                                  | {2'b00, cu_shift[11:6] & jsu_pkg::Utf8Mask};
                            burst.res[2].out_byte = jsu_pkg::Utf8Cont
                                                  | {2'b00, cu_shift[5:0] & jsu_pkg::Utf8Mask};
                        end
                    end
                end
            end
            jsu_pkg::MODE_ELF, jsu_pkg::MODE_ECR:
            begin
                if (!end_of_input &&
                    ((mode_reg == jsu_pkg::MODE_ELF && in_byte == jsu_pkg::ChrCr) ||
                     (mode_reg == jsu_pkg::MODE_ECR && in_byte == jsu_pkg::ChrLf)))
                begin
                    mode_next = jsu_pkg::MODE_STR;
                end
                else
                begin
                    mode_next    = str_mode;
                    burst.count  = {1'b0, str_has};
                    burst.res[0] = str_res;
                end
            end
            default:
            begin
                mode_next = jsu_pkg::MODE_IDLE;
                if (!end_of_input &&
                    (in_byte == jsu_pkg::ChrDquote || in_byte == jsu_pkg::ChrSquote))
                begin
                    quote_dbl_next = (in_byte == jsu_pkg::ChrDquote);
                    mode_next      = jsu_pkg::MODE_STR;
                end
            end
        endcase

        // flag the final beat of the burst
        for (int i = 0; i < jsu_pkg::MaxResults; i++)
        begin
            burst.res[i].last = (burst.count == 2'(i + 1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= jsu_pkg::MODE_IDLE;
            quote_dbl_reg <= 1'b0;
            digits_reg    <= 2'd0;
            code_unit_reg <= '0;
        end
        else if (step_en)
        begin
            mode_reg      <= mode_next;
            quote_dbl_reg <= quote_dbl_next;
            digits_reg    <= digits_next;
            code_unit_reg <= code_unit_next;
        end
    end

endmodule

/* rtl/core/jsu_queue.sv */
// Result queue: takes up to three result beats per cycle, hands out one
// per cycle while out_ready is high. Depends on jsu_pkg.
module jsu_queue
#(
    parameter int unsigned Depth = jsu_pkg::QueueDepth
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  jsu_pkg::burst_t  burst,
    output logic             room,      // space for a full burst
    output logic             out_valid,
    input  logic             out_ready,
    output jsu_pkg::result_t out_res
);

    localparam int unsigned Aw = $clog2(Depth);

    jsu_pkg::result_t mem [Depth];
    logic [Aw-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Aw-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Aw:0]   count_reg, count_next;
    logic          pop;
    logic [1:0]    n_in;

    assign n_in      = push ? burst.count : 2'd0;
    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != '0);
    assign out_res   = mem[rd_ptr_reg];
    assign room      = (count_reg <= (Aw+1)'(Depth - jsu_pkg::MaxResults));

    assign wr_ptr_next = wr_ptr_reg + Aw'(n_in);
    assign rd_ptr_next = rd_ptr_reg + Aw'(pop);
    assign count_next  = count_reg + (Aw+1)'(n_in) - (Aw+1)'(pop);

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < jsu_pkg::MaxResults; i++)
        begin
            if (2'(i) < n_in)
            begin
                mem[wr_ptr_reg + Aw'(i)] <= burst.res[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* rtl/core/json_string_unescaper.sv */
// Top level of the JSON string literal unescaper (UTF-8 output).
// Depends on jsu_pkg, jsu_if, jsu_decode and jsu_queue.
//
//  Channel | Dir | Beat payload              | Accepted when
//  --------+-----+---------------------------+------------------------
//  src     | in  | in_byte, end_of_input     | src.valid && src.ready
//  dst     | out | out_byte, kind, last      | dst.valid && dst.ready
//
// One source byte is taken per cycle while src is ready. It is decoded in the
// cycle it is accepted and its 0..3 result beats are written into the queue
// at that edge; dst offers them after earlier results. Results leave one per
// cycle while dst is ready, so only the fourth hex digit of a \u escape (up
// to three UTF-8 bytes) can drain slower than bytes arrive; the queue absorbs
// that and src.ready drops while fewer than three slots are free. Reset
// (rst_n low, async) returns the decoder to idle and empties the queue.
// A stall on dst never loses a beat; src simply stalls behind it.
module json_string_unescaper
#(
    parameter int unsigned QueueDepth = jsu_pkg::QueueDepth  // power of two, >= 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    jsu_in_if.sink     src,
    jsu_out_if.source  dst
);

    jsu_pkg::burst_t  burst;
    jsu_pkg::result_t head;
    logic             room;
    logic             step_en;

    // Input side is ready whenever a worst-case burst fits in the queue.
    assign src.ready = room;
    assign step_en   = src.valid && room;

    jsu_decode u_decode
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .step_en      (step_en),
        .in_byte      (src.in_byte),
        .end_of_input (src.end_of_input),
        .burst        (burst)
    );

    jsu_queue
    #(
        .Depth (QueueDepth)
    )
    u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (step_en),
        .burst     (burst),
        .room      (room),
        .out_valid (dst.valid),
        .out_ready (dst.ready),
        .out_res   (head)
    );

    assign dst.out_byte = head.out_byte;
    assign dst.kind     = head.kind;
    assign dst.last     = head.last;

endmodule
